// ===== hw/rtl/wodr_pkg.sv =====
// Package: constants, sine table function and shared types for wheel odometry.
`default_nettype none
package wodr_pkg;
    localparam int SINE_DEPTH_DEF = 1441;
    localparam int TICKS_DEF      = 20;
    localparam logic [15:0] SCALE_RESET  = 16'd18678;
    localparam logic [7:0]  THRESH_RESET = 8'd4;
    localparam logic [12:0] FULL_TURN    = 13'd5760;
    localparam logic [12:0] QUADRANT     = 13'd1440;
    localparam logic [0:0]  REG_SCALE    = 1'b0;
    localparam logic [0:0]  REG_THRESH   = 1'b1;

    // serial multiplier request
    typedef struct packed {
        logic        start;
        logic [10:0] mag;    // |sum|
        logic [15:0] scale;
        logic [14:0] trig_a;
        logic [14:0] trig_b;
    } mul_req_t;

    // shift-subtract quotient, used only on constants while building the table
    function automatic longint unsigned table_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Q0.15 quarter-wave sine entry, Taylor series in Q30 (elaboration/ROM logic)
    function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned depth);
        longint unsigned span, x, x2, term;
        longint sum, v;
        span = 64'(depth - 1);
        x = table_div(64'd1686629713 * idx + (span >> 1), span);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = table_div((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = ((sum << 15) + (64'sd1 << 29)) >>> 30;
        if (v > 32767)
            v = 32767;
        return v[14:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/wodr_rom.sv =====
// Sine ROM: registered read of one quarter-wave entry.
`default_nettype none
module wodr_rom
    import wodr_pkg::*;
#(
    parameter int DEPTH = SINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)(
    input  wire logic          clk,
    input  wire logic [AW-1:0] addr,
    output logic      [14:0]   data
);
    logic [14:0] rom [DEPTH];
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            rom[i] = sine_entry(i, DEPTH);
    end
    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/wodr_mul.sv =====
// Bit-serial multiplier: |sum|*scale then times two trig values, one bit per cycle.
`default_nettype none
module wodr_mul
    import wodr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  mul_req_t         req,
    output logic             done,
    output logic [41:0]      prod_a,
    output logic [41:0]      prod_b
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_P1   = 2'd1;
    localparam logic [1:0] S_P2   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] sh1_reg, sh1_next;
    logic [26:0] acc1_reg, acc1_next;
    logic [26:0] mc_reg, mc_next;
    logic [14:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [41:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [41:0] mc2_reg, mc2_next;
    logic        done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sh1_next = sh1_reg;
        acc1_next = acc1_reg;
        mc_next = mc_reg;
        sa_next = sa_reg;
        sb_next = sb_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        mc2_next = mc2_reg;
        done_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next = S_P1;
                    cnt_next = 5'd0;
                    sh1_next = req.scale;
                    mc_next = {16'd0, req.mag};
                    acc1_next = '0;
                    sa_next = req.trig_a;
                    sb_next = req.trig_b;
                end
            end
            S_P1:
            begin
                if (sh1_reg[0])
                    acc1_next = acc1_reg + mc_reg;
                sh1_next = sh1_reg >> 1;
                mc_next = mc_reg << 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = S_P2;
                    cnt_next = 5'd0;
                    pa_next = '0;
                    pb_next = '0;
                end
            end
            S_P2:
            begin
                if (cnt_reg == 5'd0)
                    mc2_next = {15'd0, acc1_reg} << 1;
                else
                    mc2_next = mc2_reg << 1;
                if (sa_reg[0])
                    pa_next = pa_reg + ((cnt_reg == 5'd0) ? {15'd0, acc1_reg} : mc2_reg);
                if (sb_reg[0])
                    pb_next = pb_reg + ((cnt_reg == 5'd0) ? {15'd0, acc1_reg} : mc2_reg);
                sa_next = sa_reg >> 1;
                sb_next = sb_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd14)
                begin
                    state_next = S_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh1_reg <= sh1_next;
        acc1_reg <= acc1_next;
        mc_reg <= mc_next;
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        mc2_reg <= mc2_next;
    end

    assign done = done_reg;
    assign prod_a = pa_reg;
    assign prod_b = pb_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/wheel_odometry_dead_reckoning.sv =====
// Top level: wheel odometry dead reckoning with APB registers.
// Each input beat passes through the index divide, the ROM reads (S_RD1 to S_RD3),
// the serial multiply and the update; in_stall stays high until the state is idle
// again, so the next beat is taken only after the current one has been updated.
// A finished result waits in the output register while the next beat is computed;
// the update waits only while that register is full and out_stall is high. Reset
// (rst_n, async low) clears the position and speed sums and restores register defaults.
`default_nettype none
module wheel_odometry_dead_reckoning
    import wodr_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int TICKS_PER_SECOND = TICKS_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:2]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [9:0]         left_clicks,
    input  wire logic [9:0]         right_clicks,
    input  wire logic               left_reverse,
    input  wire logic               right_reverse,
    input  wire logic [12:0]        heading_sixteenths,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic               position_reset,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      step_x,
    output logic signed [15:0]      step_y,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [20:0]      odo_speed_x,
    output logic signed [20:0]      odo_speed_y,
    output logic signed [15:0]      gated_accel_x,
    output logic signed [15:0]      gated_accel_y,
    output logic signed [31:0]      imu_speed_x,
    output logic signed [31:0]      imu_speed_y,
    output logic [8:0]              heading_degrees
);
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int SPAN = SINE_TABLE_DEPTH - 1;
    localparam int NW = $clog2(1440 * (2 ** AW));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_RD3  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    logic [15:0] scale_reg;
    logic [7:0]  thresh_reg;
    logic        wr;
    assign wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESH) ? {24'd0, thresh_reg} : {16'd0, scale_reg};

    logic [2:0]  state_reg, state_next;
    logic [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [12:0] head_reg;
    logic [9:0]  lc_reg, rc_reg;
    logic        lr_reg, rr_reg, pr_reg;
    logic signed [15:0] ax_reg, ay_reg;
    logic [11:0] rem_reg;
    logic [1:0]  quad_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] den_reg;
    logic [AW:0]   qt_reg;
    logic [AW:0]   idx_f_reg;
    logic [4:0]    dcnt_reg;
    logic          dpass_reg;
    logic [14:0]   sf_reg;
    logic [AW-1:0] rom_addr;
    logic [14:0]   rom_data;
    logic          ov_reg;
    logic signed [15:0] sx_o, sy_o, gx_o, gy_o;
    logic signed [31:0] px_o, py_o, vx_o, vy_o;
    logic signed [20:0] ox_o, oy_o;
    logic [8:0]   deg_o;
    mul_req_t     mreq;
    logic         mdone;
    logic [41:0]  pa, pb;

    logic signed [11:0] sum_s;
    logic [10:0]        sum_mag;
    logic               zero_d;
    assign sum_s = (lr_reg ? -$signed({2'b0, lc_reg}) : $signed({2'b0, lc_reg}))
                 + (rr_reg ? -$signed({2'b0, rc_reg}) : $signed({2'b0, rc_reg}));
    assign sum_mag = sum_s[11] ? 11'(-sum_s) : sum_s[10:0];
    assign zero_d = (lc_reg == 10'd0) || (rc_reg == 10'd0) || (sum_s == 12'sd0)
                  || (scale_reg == 16'd0);

    // restoring divide of rem*SPAN+720 by 1440, one quotient bit per cycle
    logic [NW:0] trial;
    assign trial = {1'b0, num_reg} - {1'b0, den_reg};
    logic [AW-1:0] idx_clamp;
    assign idx_clamp = (qt_reg > (AW+1)'(SPAN)) ? AW'(SPAN) : qt_reg[AW-1:0];
    // back index: one higher when the forward index was an exact half tie
    assign rom_addr = (state_reg == S_RD1) ? idx_clamp
                    : AW'(SPAN - 32'(idx_f_reg) + 32'(num_reg == '0));

    wodr_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom (
        .clk(clk), .addr(rom_addr), .data(rom_data)
    );

    // sampled at the multiply start, while the back entry is on the ROM output
    logic [14:0] trig_s, trig_c;
    always_comb
    begin
        unique case (quad_reg)
            2'd0: begin trig_s = sf_reg; trig_c = rom_data; end
            2'd1: begin trig_s = rom_data; trig_c = sf_reg; end
            2'd2: begin trig_s = sf_reg; trig_c = rom_data; end
            default: begin trig_s = rom_data; trig_c = sf_reg; end
        endcase
    end
    logic neg_s, neg_c;
    assign neg_s = sum_s[11] ^ quad_reg[1];
    assign neg_c = sum_s[11] ^ (quad_reg == 2'd1 || quad_reg == 2'd2);

    assign mreq.start  = (state_reg == S_RD3);
    assign mreq.mag    = sum_mag;
    assign mreq.scale  = scale_reg;
    assign mreq.trig_a = trig_s;
    assign mreq.trig_b = trig_c;

    wodr_mul u_mul (
        .clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .prod_a(pa), .prod_b(pb)
    );

    logic [11:0] ma, mb;
    assign ma = 12'((pa + 42'h4000_0000) >> 31);
    assign mb = 12'((pb + 42'h4000_0000) >> 31);
    logic signed [15:0] stx, sty;
    assign stx = zero_d ? 16'sd0 : (neg_s ? -$signed({4'd0, ma}) : $signed({4'd0, ma}));
    assign sty = zero_d ? 16'sd0 : (neg_c ? -$signed({4'd0, mb}) : $signed({4'd0, mb}));

    logic [15:0] amx, amy;
    assign amx = ax_reg[15] ? 16'(-ax_reg) : ax_reg;
    assign amy = ay_reg[15] ? 16'(-ay_reg) : ay_reg;
    logic passx, passy;
    assign passx = amx >= {8'd0, thresh_reg};
    assign passy = amy >= {8'd0, thresh_reg};
    logic signed [31:0] hx, hy;
    assign hx = ax_reg[15] ? -32'(($signed({1'b0, amx}) + 17'sd1) >>> 1)
                           : 32'(($signed({1'b0, amx}) + 17'sd1) >>> 1);
    assign hy = ay_reg[15] ? -32'(($signed({1'b0, amy}) + 17'sd1) >>> 1)
                           : 32'(($signed({1'b0, amy}) + 17'sd1) >>> 1);
    logic [31:0] vxb, vyb;
    assign vxb = pr_reg ? 32'd0 : vx_reg;
    assign vyb = pr_reg ? 32'd0 : vy_reg;

    logic [12:0] hd_sum;
    assign hd_sum = head_reg + 13'd8;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && !in_stall) state_next = S_DIV;
            S_DIV:   if (dcnt_reg == 5'd0 && dpass_reg) state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_MUL;
            S_MUL:   if (mdone) state_next = S_UPD;
            S_UPD:   if (!(ov_reg && out_stall)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scale_reg <= SCALE_RESET;
            thresh_reg <= THRESH_RESET;
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            ov_reg <= 1'b0;
            dcnt_reg <= '0;
            dpass_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                if (paddr[2] == REG_SCALE)
                    scale_reg <= pwdata[15:0];
                else
                    thresh_reg <= pwdata[7:0];
            end
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == S_IDLE && in_valid && !in_stall)
            begin
                dcnt_reg <= 5'(AW);
                dpass_reg <= 1'b0;
            end
            else if (state_reg == S_DIV)
            begin
                if (dcnt_reg == 5'd0)
                    dpass_reg <= 1'b1;
                else
                    dcnt_reg <= dcnt_reg - 5'd1;
            end
            if (state_reg == S_UPD && !(ov_reg && out_stall))
            begin
                ov_reg <= 1'b1;
                px_reg <= pr_reg ? 32'd0 : px_reg + 32'(stx);
                py_reg <= pr_reg ? 32'd0 : py_reg + 32'(sty);
                vx_reg <= zero_d ? 32'd0 : (passx ? vxb + hx : vxb);
                vy_reg <= zero_d ? 32'd0 : (passy ? vyb + hy : vyb);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            lc_reg <= left_clicks;
            rc_reg <= right_clicks;
            lr_reg <= left_reverse;
            rr_reg <= right_reverse;
            pr_reg <= position_reset;
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            head_reg <= (heading_sixteenths >= FULL_TURN) ? heading_sixteenths - FULL_TURN
                                                           : heading_sixteenths;
            quad_reg <= '0;
            rem_reg <= '0;
        end
        if (state_reg == S_DIV && dcnt_reg == 5'(AW) && !dpass_reg)
        begin
            // quadrant by compare-subtract
            if (head_reg >= 13'd4320)
            begin quad_reg <= 2'd3; rem_reg <= 12'(head_reg - 13'd4320); end
            else if (head_reg >= 13'd2880)
            begin quad_reg <= 2'd2; rem_reg <= 12'(head_reg - 13'd2880); end
            else if (head_reg >= QUADRANT)
            begin quad_reg <= 2'd1; rem_reg <= 12'(head_reg - QUADRANT); end
            else
            begin quad_reg <= 2'd0; rem_reg <= 12'(head_reg); end
        end
        if (state_reg == S_DIV && dcnt_reg == 5'(AW - 1))
        begin
            num_reg <= NW'(32'(rem_reg) * SPAN + 720);
            den_reg <= NW'(1440 * (2 ** (AW - 1)));
            qt_reg <= '0;
        end
        else if (state_reg == S_DIV && dcnt_reg < 5'(AW - 1) || dpass_reg && state_reg == S_DIV)
        begin
            if (!trial[NW])
            begin
                num_reg <= trial[NW-1:0];
                qt_reg <= {qt_reg[AW-1:0], 1'b1};
            end
            else
                qt_reg <= {qt_reg[AW-1:0], 1'b0};
            den_reg <= den_reg >> 1;
        end
        if (state_reg == S_RD1)
            idx_f_reg <= qt_reg;
        if (state_reg == S_RD2)
            sf_reg <= rom_data;
        if (state_reg == S_UPD && !(ov_reg && out_stall))
        begin
            sx_o <= stx;
            sy_o <= sty;
            px_o <= pr_reg ? 32'sd0 : $signed(px_reg + 32'(stx));
            py_o <= pr_reg ? 32'sd0 : $signed(py_reg + 32'(sty));
            ox_o <= pr_reg ? 21'sd0 : 21'(32'(stx) * TICKS_PER_SECOND);
            oy_o <= pr_reg ? 21'sd0 : 21'(32'(sty) * TICKS_PER_SECOND);
            gx_o <= (zero_d || !passx) ? 16'sd0 : ax_reg;
            gy_o <= (zero_d || !passy) ? 16'sd0 : ay_reg;
            vx_o <= zero_d ? 32'sd0 : $signed(passx ? vxb + hx : vxb);
            vy_o <= zero_d ? 32'sd0 : $signed(passy ? vyb + hy : vyb);
            deg_o <= (hd_sum[12:4] > 9'd359) ? 9'd0 : hd_sum[12:4];
        end
    end

    assign out_valid = ov_reg;
    assign step_x = sx_o;
    assign step_y = sy_o;
    assign pos_x = px_o;
    assign pos_y = py_o;
    assign odo_speed_x = ox_o;
    assign odo_speed_y = oy_o;
    assign gated_accel_x = gx_o;
    assign gated_accel_y = gy_o;
    assign imu_speed_x = vx_o;
    assign imu_speed_y = vy_o;
    assign heading_degrees = deg_o;

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("busy without stall");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg) else $error("result dropped");
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mdone |-> (state_reg == S_MUL)) else $error("stray multiply done");
endmodule
`default_nettype wire
